// ===== design/dpm_pkg.sv =====
// ----------------------------------------------------------------------------
// dpm_pkg
// Shared sizes, codes and memory port types of the demand paging swap manager.
// ----------------------------------------------------------------------------
package dpm_pkg;

    localparam int FRAME_COUNT   = 4;
    localparam int PAGE_BYTES    = 16;
    localparam int ENTRY_BYTES   = 4;
    localparam int SWAP_SLOTS    = 64;
    localparam int PROCESS_COUNT = 4;

    localparam int ENTRIES  = PAGE_BYTES / ENTRY_BYTES;
    localparam int VA_LIMIT = ENTRIES * PAGE_BYTES;
    localparam int FRAME_W  = $clog2(FRAME_COUNT);
    localparam int PAGE_W   = $clog2(PAGE_BYTES);
    localparam int ENT_W    = $clog2(ENTRIES);
    localparam int EB_W     = $clog2(ENTRY_BYTES);
    localparam int SLOT_W   = $clog2(SWAP_SLOTS);
    localparam int FADDR_W  = FRAME_W + PAGE_W;
    localparam int SADDR_W  = SLOT_W + PAGE_W;
    localparam int CNT_W    = SADDR_W;

    localparam int KIND_W = 2;
    localparam int PID_W  = 2;
    localparam int VA_W   = 8;
    localparam int BYTE_W = 8;
    localparam int EV_W   = 4;
    localparam int OFR_W  = 2;
    localparam int OSL_W  = 6;
    localparam int OPA_W  = 6;
    localparam int OVP_W  = 2;

    localparam logic [KIND_W-1:0] K_MAP   = 2'd0;
    localparam logic [KIND_W-1:0] K_STORE = 2'd1;
    localparam logic [KIND_W-1:0] K_LOAD  = 2'd2;
    localparam logic [KIND_W-1:0] K_BAD   = 2'd3;

    localparam logic [EV_W-1:0] EV_SWAP_OUT  = 4'd0;
    localparam logic [EV_W-1:0] EV_TABLE_IN  = 4'd1;
    localparam logic [EV_W-1:0] EV_TABLE_NEW = 4'd2;
    localparam logic [EV_W-1:0] EV_MAPPED    = 4'd3;
    localparam logic [EV_W-1:0] EV_PERM      = 4'd4;
    localparam logic [EV_W-1:0] EV_STORED    = 4'd5;
    localparam logic [EV_W-1:0] EV_LOADED    = 4'd6;
    localparam logic [EV_W-1:0] EV_BAD_REQ   = 4'd7;
    localparam logic [EV_W-1:0] EV_BAD_VAL   = 4'd8;
    localparam logic [EV_W-1:0] EV_SAME      = 4'd9;
    localparam logic [EV_W-1:0] EV_NO_MAP    = 4'd10;
    localparam logic [EV_W-1:0] EV_RD_ONLY   = 4'd11;
    localparam logic [EV_W-1:0] EV_SWAP_FULL = 4'd12;

    localparam logic [EB_W-1:0] B_FRAME = 2'd0;
    localparam logic [EB_W-1:0] B_VALID = 2'd1;
    localparam logic [EB_W-1:0] B_WRITE = 2'd2;
    localparam logic [EB_W-1:0] B_PRES  = 2'd3;

    typedef enum logic [1:0] {
        FK_EMPTY,
        FK_DATA,
        FK_TABLE
    } t_fkind;

    typedef struct packed {
        logic               we;
        logic [FADDR_W-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic [FADDR_W-1:0] raddr;
    } t_fmem_req;

    typedef struct packed {
        logic               we;
        logic [SADDR_W-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic [SADDR_W-1:0] raddr;
    } t_smem_req;

endpackage

// ===== design/dpm_ram.sv =====
// ----------------------------------------------------------------------------
// dpm_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module dpm_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [1<<ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/dpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpm_ctrl
// Request sequencer: table lookups, victim choice, page exchange and events.
// ----------------------------------------------------------------------------
module dpm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dpm_pkg::KIND_W-1:0] i_kind,
    input  logic [dpm_pkg::PID_W-1:0]  i_pid,
    input  logic [dpm_pkg::VA_W-1:0]   i_virtual_address,
    input  logic [dpm_pkg::BYTE_W-1:0] i_value,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [dpm_pkg::EV_W-1:0]   o_event_res,
    output logic [dpm_pkg::OFR_W-1:0]  o_frame_index,
    output logic [dpm_pkg::OSL_W-1:0]  o_swap_slot,
    output logic [dpm_pkg::OPA_W-1:0]  o_physical_address,
    output logic [dpm_pkg::OVP_W-1:0]  o_virtual_page,
    output logic [dpm_pkg::BYTE_W-1:0] o_read_data,
    output logic                       o_last,
    output dpm_pkg::t_fmem_req         o_fmem,
    input  logic [dpm_pkg::BYTE_W-1:0] i_frdata,
    output dpm_pkg::t_smem_req         o_smem,
    input  logic [dpm_pkg::BYTE_W-1:0] i_srdata
);
    import dpm_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_CHECK, S_ENS, S_EN_GF, S_EN_X, S_NT_GF, S_NT_CLR,
        S_NT_FIN, S_ENT_RD, S_DECIDE, S_MP_UPD, S_MP_GF, S_MP_WR, S_AC_GF,
        S_AC_X, S_AC_W3, S_AC_OP, S_LD_EM, S_GF_FREE, S_GF_SCAN, S_GF_VICT,
        S_RT_RD, S_RT_CHK, S_RT_W3, S_RT_W0, S_GF_XCH, S_XCH, S_GF_FIN
    } t_state;

    t_state              r_state, r_gret, r_xret;
    logic [CNT_W-1:0]    r_cnt;
    logic [KIND_W-1:0]   r_kind;
    logic [PID_W-1:0]    r_pid;
    logic [VA_W-1:0]     r_va;
    logic [BYTE_W-1:0]   r_val;
    logic [FRAME_W-1:0]  r_tf  [PROCESS_COUNT];
    logic [SLOT_W-1:0]   r_ts  [PROCESS_COUNT];
    logic                r_tin [PROCESS_COUNT];
    logic                r_tsw [PROCESS_COUNT];
    t_fkind              r_fk  [FRAME_COUNT];
    logic [PID_W-1:0]    r_fo  [FRAME_COUNT];
    logic                r_used [SWAP_SLOTS];
    logic [FRAME_W-1:0]  r_vptr;
    logic                r_gok;
    logic [FRAME_W-1:0]  r_gfr;
    logic [SLOT_W-1:0]   r_gs;
    logic                r_rt_sw;
    logic [SLOT_W-1:0]   r_rt_idx;
    logic [ENT_W-1:0]    r_rt_e;
    logic [BYTE_W-1:0]   r_rb [ENTRY_BYTES];
    logic [BYTE_W-1:0]   r_eb [ENTRY_BYTES];
    logic [FRAME_W-1:0]  r_xf;
    logic [SLOT_W-1:0]   r_xs;
    logic [FRAME_W-1:0]  r_f;
    logic [SLOT_W-1:0]   r_from;

    logic                r_o_valid;
    logic [EV_W-1:0]     r_o_ev;
    logic [OFR_W-1:0]    r_o_fr;
    logic [OSL_W-1:0]    r_o_sl;
    logic [OPA_W-1:0]    r_o_pa;
    logic [OVP_W-1:0]    r_o_vp;
    logic [BYTE_W-1:0]   r_o_rd;
    logic                r_o_last;

    logic [ENT_W-1:0]    vp;
    logic [PAGE_W-1:0]   off;
    logic [CNT_W-1:0]    cnt_m1;
    logic [EB_W-1:0]     bidx;
    logic                ff_found;
    logic [FRAME_W-1:0]  ff_idx;
    logic                v_found;
    logic [FRAME_W-1:0]  v_c;
    logic [FRAME_W-1:0]  v_next;
    logic [PID_W-1:0]    own;
    logic [BYTE_W-1:0]   rt_rdata;
    int                  ci;

    assign vp       = r_va[PAGE_W +: ENT_W];
    assign off      = r_va[PAGE_W-1:0];
    assign cnt_m1   = r_cnt - 1'b1;
    assign bidx     = cnt_m1[EB_W-1:0];
    assign rt_rdata = r_rt_sw ? i_srdata : i_frdata;
    assign own      = r_fo[v_c];
    assign v_next   = (v_c == FRAME_W'(FRAME_COUNT-1)) ? '0 : v_c + 1'b1;

    // lowest free frame
    always_comb begin
        ff_found = 1'b0;
        ff_idx   = '0;
        for (int f = FRAME_COUNT-1; f >= 0; f--) begin
            if (r_fk[f] == FK_EMPTY) begin
                ff_found = 1'b1;
                ff_idx   = FRAME_W'(f);
            end
        end
    end

    // round-robin victim, skipping the requester's own table
    always_comb begin
        v_found = 1'b0;
        v_c     = '0;
        ci      = 0;
        for (int k = 0; k < FRAME_COUNT; k++) begin
            ci = int'(r_vptr) + k;
            if (ci >= FRAME_COUNT) begin
                ci = ci - FRAME_COUNT;
            end
            if (!v_found && !(r_fk[ci] == FK_TABLE && r_fo[ci] == r_pid)) begin
                v_found = 1'b1;
                v_c     = FRAME_W'(ci);
            end
        end
    end

    // memory ports
    always_comb begin
        o_fmem = '0;
        o_smem = '0;
        case (r_state)
            S_CLR: begin
                o_smem.we    = 1'b1;
                o_smem.waddr = r_cnt[SADDR_W-1:0];
                o_fmem.we    = (32'(r_cnt) < FRAME_COUNT*PAGE_BYTES);
                o_fmem.waddr = r_cnt[FADDR_W-1:0];
            end
            S_XCH: begin
                o_fmem.raddr = {r_xf, r_cnt[PAGE_W-1:0]};
                o_smem.raddr = {r_xs, r_cnt[PAGE_W-1:0]};
                if (r_cnt != '0) begin
                    o_fmem.we    = 1'b1;
                    o_fmem.waddr = {r_xf, cnt_m1[PAGE_W-1:0]};
                    o_fmem.wdata = i_srdata;
                    o_smem.we    = 1'b1;
                    o_smem.waddr = {r_xs, cnt_m1[PAGE_W-1:0]};
                    o_smem.wdata = i_frdata;
                end
            end
            S_RT_RD: begin
                o_fmem.raddr = {r_rt_idx[FRAME_W-1:0], r_rt_e, r_cnt[EB_W-1:0]};
                o_smem.raddr = {r_rt_idx, r_rt_e, r_cnt[EB_W-1:0]};
            end
            S_RT_W3, S_RT_W0: begin
                o_fmem.we    = !r_rt_sw;
                o_smem.we    = r_rt_sw;
                o_fmem.waddr = {r_rt_idx[FRAME_W-1:0], r_rt_e,
                                (r_state == S_RT_W3) ? B_PRES : B_FRAME};
                o_smem.waddr = {r_rt_idx, r_rt_e,
                                (r_state == S_RT_W3) ? B_PRES : B_FRAME};
                o_fmem.wdata = (r_state == S_RT_W3) ? '0 : BYTE_W'(r_gs);
                o_smem.wdata = o_fmem.wdata;
            end
            S_NT_CLR: begin
                o_fmem.we    = 1'b1;
                o_fmem.waddr = {r_gfr, r_cnt[PAGE_W-1:0]};
            end
            S_ENT_RD: begin
                o_fmem.raddr = {r_tf[r_pid], vp, r_cnt[EB_W-1:0]};
            end
            S_MP_UPD: begin
                o_fmem.we    = 1'b1;
                o_fmem.waddr = {r_tf[r_pid], vp, B_WRITE};
                o_fmem.wdata = r_val;
            end
            S_MP_WR: begin
                o_fmem.we    = 1'b1;
                o_fmem.waddr = {r_tf[r_pid], vp, r_cnt[EB_W-1:0]};
                case (r_cnt[EB_W-1:0])
                    B_FRAME: o_fmem.wdata = BYTE_W'(r_gfr);
                    B_WRITE: o_fmem.wdata = r_val;
                    default: o_fmem.wdata = BYTE_W'(1);
                endcase
            end
            S_AC_X: begin
                o_fmem.we    = 1'b1;
                o_fmem.waddr = {r_tf[r_pid], vp, B_FRAME};
                o_fmem.wdata = BYTE_W'(r_gfr);
            end
            S_AC_W3: begin
                o_fmem.we    = 1'b1;
                o_fmem.waddr = {r_tf[r_pid], vp, B_PRES};
                o_fmem.wdata = BYTE_W'(1);
            end
            S_AC_OP: begin
                o_fmem.raddr = {r_f, off};
                o_fmem.waddr = {r_f, off};
                o_fmem.wdata = r_val;
                o_fmem.we    = (r_kind == K_STORE) && (r_eb[B_WRITE] != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_gret    <= S_IDLE;
            r_xret    <= S_IDLE;
            r_cnt     <= '0;
            r_vptr    <= '0;
            r_gok     <= 1'b0;
            r_o_valid <= 1'b0;
            for (int p = 0; p < PROCESS_COUNT; p++) begin
                r_tin[p] <= 1'b0;
                r_tsw[p] <= 1'b0;
            end
            for (int f = 0; f < FRAME_COUNT; f++) begin
                r_fk[f] <= FK_EMPTY;
                r_fo[f] <= '0;
            end
            for (int s = 0; s < SWAP_SLOTS; s++) begin
                r_used[s] <= 1'b0;
            end
        end else begin
            r_o_valid <= 1'b0;
            r_o_ev    <= '0;
            r_o_fr    <= '0;
            r_o_sl    <= '0;
            r_o_pa    <= '0;
            r_o_rd    <= '0;
            r_o_last  <= 1'b0;
            r_o_vp    <= OVP_W'(r_va >> PAGE_W);
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SWAP_SLOTS*PAGE_BYTES-1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_kind  <= i_kind;
                        r_pid   <= i_pid;
                        r_va    <= i_virtual_address;
                        r_val   <= i_value;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_kind == K_BAD || 32'(r_va) >= VA_LIMIT
                            || 32'(r_pid) >= PROCESS_COUNT) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_BAD_REQ;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (r_kind == K_MAP && r_val > BYTE_W'(1)) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_BAD_VAL;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_ENS;
                    end
                end
                S_ENS: begin
                    if (r_tin[r_pid]) begin
                        r_cnt   <= '0;
                        r_state <= S_ENT_RD;
                    end else if (!r_tsw[r_pid]) begin
                        if (r_kind == K_MAP) begin
                            r_gret  <= S_NT_GF;
                            r_state <= S_GF_FREE;
                        end else begin
                            r_o_valid <= 1'b1;
                            r_o_ev    <= EV_NO_MAP;
                            r_o_last  <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        r_gret  <= S_EN_GF;
                        r_state <= S_GF_FREE;
                    end
                end
                S_EN_GF: begin
                    if (!r_gok) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_SWAP_FULL;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_xf    <= r_gfr;
                        r_xs    <= r_ts[r_pid];
                        r_xret  <= S_EN_X;
                        r_cnt   <= '0;
                        r_state <= S_XCH;
                    end
                end
                S_EN_X: begin
                    r_used[r_ts[r_pid]] <= 1'b0;
                    r_tsw[r_pid]        <= 1'b0;
                    r_tin[r_pid]        <= 1'b1;
                    r_tf[r_pid]         <= r_gfr;
                    r_fk[r_gfr]         <= FK_TABLE;
                    r_fo[r_gfr]         <= r_pid;
                    r_o_valid           <= 1'b1;
                    r_o_ev              <= EV_TABLE_IN;
                    r_o_fr              <= OFR_W'(r_gfr);
                    r_o_sl              <= OSL_W'(r_ts[r_pid]);
                    r_cnt               <= '0;
                    r_state             <= S_ENT_RD;
                end
                S_NT_GF: begin
                    if (!r_gok) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_SWAP_FULL;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_NT_CLR;
                    end
                end
                S_NT_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(PAGE_BYTES-1)) begin
                        r_state <= S_NT_FIN;
                    end
                end
                S_NT_FIN: begin
                    r_fk[r_gfr]  <= FK_TABLE;
                    r_fo[r_gfr]  <= r_pid;
                    r_tf[r_pid]  <= r_gfr;
                    r_tin[r_pid] <= 1'b1;
                    r_o_valid    <= 1'b1;
                    r_o_ev       <= EV_TABLE_NEW;
                    r_o_fr       <= OFR_W'(r_gfr);
                    r_cnt        <= '0;
                    r_state      <= S_ENT_RD;
                end
                S_ENT_RD: begin
                    if (r_cnt != '0) begin
                        r_eb[bidx] <= i_frdata;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ENTRY_BYTES)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_kind == K_MAP) begin
                        if (r_eb[B_VALID] != '0) begin
                            if (r_eb[B_WRITE] == r_val) begin
                                r_o_valid <= 1'b1;
                                r_o_ev    <= EV_SAME;
                                r_o_last  <= 1'b1;
                                r_state   <= S_IDLE;
                            end else begin
                                r_state <= S_MP_UPD;
                            end
                        end else begin
                            r_gret  <= S_MP_GF;
                            r_state <= S_GF_FREE;
                        end
                    end else if (r_eb[B_VALID] == '0) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_NO_MAP;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (r_eb[B_PRES] == '0) begin
                        if (32'(r_eb[B_FRAME]) >= SWAP_SLOTS) begin
                            r_o_valid <= 1'b1;
                            r_o_ev    <= EV_NO_MAP;
                            r_o_last  <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_gret  <= S_AC_GF;
                            r_state <= S_GF_FREE;
                        end
                    end else if (32'(r_eb[B_FRAME]) >= FRAME_COUNT) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_NO_MAP;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_f     <= FRAME_W'(r_eb[B_FRAME]);
                        r_from  <= '0;
                        r_state <= S_AC_OP;
                    end
                end
                S_MP_UPD: begin
                    r_o_valid <= 1'b1;
                    r_o_ev    <= EV_PERM;
                    r_o_last  <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_MP_GF: begin
                    if (!r_gok) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_SWAP_FULL;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_fk[r_gfr] <= FK_DATA;
                        r_fo[r_gfr] <= r_pid;
                        r_cnt       <= '0;
                        r_state     <= S_MP_WR;
                    end
                end
                S_MP_WR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ENTRY_BYTES-1)) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_MAPPED;
                        r_o_fr    <= OFR_W'(r_gfr);
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_AC_GF: begin
                    if (!r_gok) begin
                        r_o_valid <= 1'b1;
                        r_o_ev    <= EV_SWAP_FULL;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_xf    <= r_gfr;
                        r_xs    <= SLOT_W'(r_eb[B_FRAME]);
                        r_xret  <= S_AC_X;
                        r_cnt   <= '0;
                        r_state <= S_XCH;
                    end
                end
                S_AC_X: begin
                    r_used[r_xs] <= 1'b0;
                    r_fk[r_gfr]  <= FK_DATA;
                    r_fo[r_gfr]  <= r_pid;
                    r_from       <= r_xs;
                    r_f          <= r_gfr;
                    r_state      <= S_AC_W3;
                end
                S_AC_W3: begin
                    r_state <= S_AC_OP;
                end
                S_AC_OP: begin
                    if (r_kind == K_STORE) begin
                        r_o_valid <= 1'b1;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                        if (r_eb[B_WRITE] == '0) begin
                            r_o_ev <= EV_RD_ONLY;
                        end else begin
                            r_o_ev <= EV_STORED;
                            r_o_fr <= OFR_W'(r_f);
                            r_o_sl <= OSL_W'(r_from);
                            r_o_pa <= OPA_W'({r_f, off});
                        end
                    end else begin
                        r_state <= S_LD_EM;
                    end
                end
                S_LD_EM: begin
                    r_o_valid <= 1'b1;
                    r_o_ev    <= EV_LOADED;
                    r_o_fr    <= OFR_W'(r_f);
                    r_o_sl    <= OSL_W'(r_from);
                    r_o_pa    <= OPA_W'({r_f, off});
                    r_o_rd    <= i_frdata;
                    r_o_last  <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_GF_FREE: begin
                    if (ff_found) begin
                        r_gok   <= 1'b1;
                        r_gfr   <= ff_idx;
                        r_state <= r_gret;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_GF_SCAN;
                    end
                end
                S_GF_SCAN: begin
                    if (!r_used[r_cnt[SLOT_W-1:0]]) begin
                        r_gs    <= r_cnt[SLOT_W-1:0];
                        r_state <= S_GF_VICT;
                    end else if (r_cnt == CNT_W'(SWAP_SLOTS-1)) begin
                        r_gok   <= 1'b0;
                        r_state <= r_gret;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_GF_VICT: begin
                    if (!v_found) begin
                        r_gok   <= 1'b0;
                        r_state <= r_gret;
                    end else begin
                        r_vptr <= v_next;
                        r_gfr  <= v_c;
                        r_rt_e <= '0;
                        r_cnt  <= '0;
                        if (r_fk[v_c] == FK_DATA) begin
                            if (r_tin[own]) begin
                                r_rt_sw  <= 1'b0;
                                r_rt_idx <= SLOT_W'(r_tf[own]);
                                r_state  <= S_RT_RD;
                            end else if (r_tsw[own]) begin
                                r_rt_sw  <= 1'b1;
                                r_rt_idx <= r_ts[own];
                                r_state  <= S_RT_RD;
                            end else begin
                                r_state <= S_GF_XCH;
                            end
                        end else begin
                            r_tin[own] <= 1'b0;
                            r_tsw[own] <= 1'b1;
                            r_ts[own]  <= r_gs;
                            r_state    <= S_GF_XCH;
                        end
                    end
                end
                S_RT_RD: begin
                    if (r_cnt != '0) begin
                        r_rb[bidx] <= rt_rdata;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ENTRY_BYTES)) begin
                        r_state <= S_RT_CHK;
                    end
                end
                S_RT_CHK: begin
                    if (r_rb[B_VALID] != '0 && r_rb[B_PRES] != '0
                            && r_rb[B_FRAME] == BYTE_W'(r_gfr)) begin
                        r_state <= S_RT_W3;
                    end else if (r_rt_e == ENT_W'(ENTRIES-1)) begin
                        r_state <= S_GF_XCH;
                    end else begin
                        r_rt_e  <= r_rt_e + 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_RT_RD;
                    end
                end
                S_RT_W3: begin
                    r_state <= S_RT_W0;
                end
                S_RT_W0: begin
                    r_state <= S_GF_XCH;
                end
                S_GF_XCH: begin
                    r_xf    <= r_gfr;
                    r_xs    <= r_gs;
                    r_xret  <= S_GF_FIN;
                    r_cnt   <= '0;
                    r_state <= S_XCH;
                end
                S_XCH: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(PAGE_BYTES)) begin
                        r_state <= r_xret;
                    end
                end
                S_GF_FIN: begin
                    r_used[r_gs] <= 1'b1;
                    r_fk[r_gfr]  <= FK_EMPTY;
                    r_o_valid    <= 1'b1;
                    r_o_ev       <= EV_SWAP_OUT;
                    r_o_fr       <= OFR_W'(r_gfr);
                    r_o_sl       <= OSL_W'(r_gs);
                    r_gok        <= 1'b1;
                    r_state      <= r_gret;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_event_res        = r_o_ev;
    assign o_frame_index      = r_o_fr;
    assign o_swap_slot        = r_o_sl;
    assign o_physical_address = r_o_pa;
    assign o_virtual_page     = r_o_vp;
    assign o_read_data        = r_o_rd;
    assign o_last             = r_o_last;
endmodule

// ===== design/demand_paging_swap_manager_top.sv =====
// ----------------------------------------------------------------------------
// demand_paging_swap_manager_top
// Demand paging manager with round-robin frame replacement and a swap store.
// a request may bring in both a table and a data page, each after an eviction
//   (swap slot scan, entry fixup for a data victim, page exchange)
// requests: one at a time, set by the sequencer and one-read one-write rams
// reset: clearing sweep of every address of both rams, busy stays high meanwhile
// results come out on o_valid and cannot be stalled
// ----------------------------------------------------------------------------
module demand_paging_swap_manager_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [dpm_pkg::KIND_W-1:0] i_kind,
    input  logic [dpm_pkg::PID_W-1:0]  i_pid,
    input  logic [dpm_pkg::VA_W-1:0]   i_virtual_address,
    input  logic [dpm_pkg::BYTE_W-1:0] i_value,
    output logic                       busy,
    output logic                       o_valid,
    output logic [dpm_pkg::EV_W-1:0]   o_event_res,
    output logic [dpm_pkg::OFR_W-1:0]  o_frame_index,
    output logic [dpm_pkg::OSL_W-1:0]  o_swap_slot,
    output logic [dpm_pkg::OPA_W-1:0]  o_physical_address,
    output logic [dpm_pkg::OVP_W-1:0]  o_virtual_page,
    output logic [dpm_pkg::BYTE_W-1:0] o_read_data,
    output logic                       o_last
);
    import dpm_pkg::*;

    t_fmem_req         fmem;
    t_smem_req         smem;
    logic [BYTE_W-1:0] frdata;
    logic [BYTE_W-1:0] srdata;

    dpm_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_kind             (i_kind),
        .i_pid              (i_pid),
        .i_virtual_address  (i_virtual_address),
        .i_value            (i_value),
        .o_busy             (busy),
        .o_valid            (o_valid),
        .o_event_res        (o_event_res),
        .o_frame_index      (o_frame_index),
        .o_swap_slot        (o_swap_slot),
        .o_physical_address (o_physical_address),
        .o_virtual_page     (o_virtual_page),
        .o_read_data        (o_read_data),
        .o_last             (o_last),
        .o_fmem             (fmem),
        .i_frdata           (frdata),
        .o_smem             (smem),
        .i_srdata           (srdata)
    );

    dpm_ram #(.ADDR_W(FADDR_W), .DATA_W(BYTE_W)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fmem.we),
        .i_waddr (fmem.waddr),
        .i_wdata (fmem.wdata),
        .i_raddr (fmem.raddr),
        .o_rdata (frdata)
    );

    dpm_ram #(.ADDR_W(SADDR_W), .DATA_W(BYTE_W)) u_swap_ram (
        .i_clk   (i_clk),
        .i_we    (smem.we),
        .i_waddr (smem.waddr),
        .i_wdata (smem.wdata),
        .i_raddr (smem.raddr),
        .o_rdata (srdata)
    );
endmodule

// ===== dv/dpm_checker.sv =====
// ----------------------------------------------------------------------------
// dpm_checker
// Watches the request and event channels of the demand paging swap manager,
// keeps its own copy of frame memory, swap store, table and frame bookkeeping,
// works out the event list of every accepted request and compares each event,
// field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module dpm_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [dpm_pkg::KIND_W-1:0] i_kind,
    input  logic [dpm_pkg::PID_W-1:0]  i_pid,
    input  logic [dpm_pkg::VA_W-1:0]   i_virtual_address,
    input  logic [dpm_pkg::BYTE_W-1:0] i_value,
    input  logic                       i_valid,
    input  logic [dpm_pkg::EV_W-1:0]   i_event_res,
    input  logic [dpm_pkg::OFR_W-1:0]  i_frame_index,
    input  logic [dpm_pkg::OSL_W-1:0]  i_swap_slot,
    input  logic [dpm_pkg::OPA_W-1:0]  i_physical_address,
    input  logic [dpm_pkg::OVP_W-1:0]  i_virtual_page,
    input  logic [dpm_pkg::BYTE_W-1:0] i_read_data,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_outstanding,
    output int                         o_events_checked,
    output int                         o_pagings
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpm_pkg::*;

    localparam int MAX_EVENTS = 6;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [OFR_W-1:0]  fr;
        logic [OSL_W-1:0]  sl;
        logic [OPA_W-1:0]  pa;
        logic [OVP_W-1:0]  vp;
        logic [BYTE_W-1:0] rd;
        logic              last;
    } t_event;

    logic [7:0]         frame_mem [FRAME_COUNT*PAGE_BYTES];
    logic [7:0]         swap_mem [SWAP_SLOTS*PAGE_BYTES];
    logic [FRAME_W-1:0] tbl_frame [PROCESS_COUNT];
    bit                 tbl_in_frame [PROCESS_COUNT];
    logic [SLOT_W-1:0]  tbl_slot [PROCESS_COUNT];
    bit                 tbl_in_swap [PROCESS_COUNT];
    t_fkind             fkind [FRAME_COUNT];
    int                 fowner [FRAME_COUNT];
    t_fkind             skind [SWAP_SLOTS];
    int                 vptr;

    t_event             events_q[$];
    int                 req_events;
    logic [OVP_W-1:0]   req_vpage;

    task automatic flag(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic void clear_model();
        foreach (frame_mem[i]) frame_mem[i] = '0;
        foreach (swap_mem[i]) swap_mem[i] = '0;
        for (int p = 0; p < PROCESS_COUNT; p++) begin
            tbl_frame[p] = '0;
            tbl_slot[p] = '0;
            tbl_in_frame[p] = 0;
            tbl_in_swap[p] = 0;
        end
        for (int f = 0; f < FRAME_COUNT; f++) begin
            fkind[f] = FK_EMPTY;
            fowner[f] = 0;
        end
        foreach (skind[s]) skind[s] = FK_EMPTY;
        vptr = 0;
    endfunction

    function automatic void note(input logic [EV_W-1:0] ev, input int fr, input int sl,
                                 input int pa, input int rd, input bit last);
        t_event e;
        if (req_events >= MAX_EVENTS) return;
        e.ev = ev;
        e.fr = fr[OFR_W-1:0];
        e.sl = sl[OSL_W-1:0];
        e.pa = pa[OPA_W-1:0];
        e.vp = req_vpage;
        e.rd = rd[BYTE_W-1:0];
        e.last = last;
        events_q.push_back(e);
        req_events++;
        if (ev == EV_SWAP_OUT || ev == EV_TABLE_IN) o_pagings++;
    endfunction

    function automatic void swap_page(input int fr, input int sl);
        logic [7:0] t;
        for (int i = 0; i < PAGE_BYTES; i++) begin
            t = frame_mem[fr*PAGE_BYTES+i];
            frame_mem[fr*PAGE_BYTES+i] = swap_mem[sl*PAGE_BYTES+i];
            swap_mem[sl*PAGE_BYTES+i] = t;
        end
    endfunction

    function automatic void redirect_entry(input int owner, input int victim, input int sl);
        int base;
        bit in_frame;
        if (tbl_in_frame[owner]) begin
            in_frame = 1;
            base = tbl_frame[owner] * PAGE_BYTES;
        end else if (tbl_in_swap[owner]) begin
            in_frame = 0;
            base = tbl_slot[owner] * PAGE_BYTES;
        end else begin
            return;
        end
        for (int e = 0; e < ENTRIES; e++) begin
            int a;
            a = base + e * ENTRY_BYTES;
            if (in_frame) begin
                if (frame_mem[a+1] != 0 && frame_mem[a+3] != 0 && frame_mem[a] == victim) begin
                    frame_mem[a+3] = 0;
                    frame_mem[a] = 8'(sl);
                    return;
                end
            end else begin
                if (swap_mem[a+1] != 0 && swap_mem[a+3] != 0 && swap_mem[a] == victim) begin
                    swap_mem[a+3] = 0;
                    swap_mem[a] = 8'(sl);
                    return;
                end
            end
        end
    endfunction

    function automatic bit claim_frame(input int pid, output int fr);
        int s;
        int c;
        int own;
        bit found;
        found = 0;
        c = 0;
        fr = 0;
        for (int f = 0; f < FRAME_COUNT; f++) begin
            if (fkind[f] == FK_EMPTY) begin
                fr = f;
                return 1;
            end
        end
        for (s = 0; s < SWAP_SLOTS; s++) begin
            if (skind[s] == FK_EMPTY) break;
        end
        if (s >= SWAP_SLOTS) return 0;
        for (int k = 0; k < FRAME_COUNT; k++) begin
            c = (vptr + k) % FRAME_COUNT;
            if (!(fkind[c] == FK_TABLE && fowner[c] == pid)) begin
                found = 1;
                break;
            end
        end
        if (!found) return 0;
        vptr = (c + 1) % FRAME_COUNT;
        own = fowner[c];
        if (fkind[c] == FK_DATA) begin
            redirect_entry(own, c, s);
            swap_page(c, s);
            skind[s] = FK_DATA;
        end else begin
            tbl_in_frame[own] = 0;
            tbl_in_swap[own] = 1;
            tbl_slot[own] = SLOT_W'(s);
            swap_page(c, s);
            skind[s] = FK_TABLE;
        end
        fkind[c] = FK_EMPTY;
        note(EV_SWAP_OUT, c, s, 0, 0, 0);
        fr = c;
        return 1;
    endfunction

    // 0 table resident, 1 no table, 2 swap full
    function automatic int bring_table(input int pid);
        int f;
        int s;
        if (tbl_in_frame[pid]) return 0;
        if (!tbl_in_swap[pid]) return 1;
        if (!claim_frame(pid, f)) return 2;
        s = tbl_slot[pid];
        swap_page(f, s);
        skind[s] = FK_EMPTY;
        tbl_in_swap[pid] = 0;
        tbl_in_frame[pid] = 1;
        tbl_frame[pid] = FRAME_W'(f);
        fkind[f] = FK_TABLE;
        fowner[f] = pid;
        note(EV_TABLE_IN, f, s, 0, 0, 0);
        return 0;
    endfunction

    function automatic void map_page(input int pid, input int vp, input int val);
        int f;
        int e;
        int r;
        if (val > 1) begin
            note(EV_BAD_VAL, 0, 0, 0, 0, 1);
            return;
        end
        r = bring_table(pid);
        if (r == 2) begin
            note(EV_SWAP_FULL, 0, 0, 0, 0, 1);
            return;
        end
        if (r == 1) begin
            if (!claim_frame(pid, f)) begin
                note(EV_SWAP_FULL, 0, 0, 0, 0, 1);
                return;
            end
            for (int i = 0; i < PAGE_BYTES; i++) frame_mem[f*PAGE_BYTES+i] = '0;
            fkind[f] = FK_TABLE;
            fowner[f] = pid;
            tbl_frame[pid] = FRAME_W'(f);
            tbl_in_frame[pid] = 1;
            note(EV_TABLE_NEW, f, 0, 0, 0, 0);
        end
        e = tbl_frame[pid] * PAGE_BYTES + vp * ENTRY_BYTES;
        if (frame_mem[e+B_VALID] != 0) begin
            if (frame_mem[e+B_WRITE] == val) begin
                note(EV_SAME, 0, 0, 0, 0, 1);
                return;
            end
            frame_mem[e+B_WRITE] = 8'(val);
            note(EV_PERM, 0, 0, 0, 0, 1);
            return;
        end
        if (!claim_frame(pid, f)) begin
            note(EV_SWAP_FULL, 0, 0, 0, 0, 1);
            return;
        end
        fkind[f] = FK_DATA;
        fowner[f] = pid;
        frame_mem[e+B_FRAME] = 8'(f);
        frame_mem[e+B_VALID] = 1;
        frame_mem[e+B_WRITE] = 8'(val);
        frame_mem[e+B_PRES] = 1;
        note(EV_MAPPED, f, 0, 0, 0, 1);
    endfunction

    function automatic void access_page(input int pid, input int va, input int vp,
                                        input int val, input bit is_store);
        int e;
        int f;
        int s;
        int from;
        int pa;
        int r;
        from = 0;
        r = bring_table(pid);
        if (r == 2) begin
            note(EV_SWAP_FULL, 0, 0, 0, 0, 1);
            return;
        end
        if (r == 1) begin
            note(EV_NO_MAP, 0, 0, 0, 0, 1);
            return;
        end
        e = tbl_frame[pid] * PAGE_BYTES + vp * ENTRY_BYTES;
        if (frame_mem[e+B_VALID] == 0) begin
            note(EV_NO_MAP, 0, 0, 0, 0, 1);
            return;
        end
        if (frame_mem[e+B_PRES] == 0) begin
            s = frame_mem[e+B_FRAME];
            if (s >= SWAP_SLOTS) begin
                note(EV_NO_MAP, 0, 0, 0, 0, 1);
                return;
            end
            if (!claim_frame(pid, f)) begin
                note(EV_SWAP_FULL, 0, 0, 0, 0, 1);
                return;
            end
            swap_page(f, s);
            skind[s] = FK_EMPTY;
            fkind[f] = FK_DATA;
            fowner[f] = pid;
            frame_mem[e+B_FRAME] = 8'(f);
            frame_mem[e+B_PRES] = 1;
            from = s;
        end
        f = frame_mem[e+B_FRAME];
        if (f >= FRAME_COUNT) begin
            note(EV_NO_MAP, 0, 0, 0, 0, 1);
            return;
        end
        pa = f * PAGE_BYTES + va % PAGE_BYTES;
        if (is_store) begin
            if (frame_mem[e+B_WRITE] == 0) begin
                note(EV_RD_ONLY, 0, 0, 0, 0, 1);
                return;
            end
            frame_mem[pa] = 8'(val);
            note(EV_STORED, f, from, pa, 0, 1);
        end else begin
            note(EV_LOADED, f, from, pa, frame_mem[pa], 1);
        end
    endfunction

    function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                            input logic [PID_W-1:0] pid,
                                            input logic [VA_W-1:0] va,
                                            input logic [BYTE_W-1:0] val);
        req_events = 0;
        req_vpage = OVP_W'(va / PAGE_BYTES);
        if (kind == K_BAD || pid >= PROCESS_COUNT || va >= VA_LIMIT) begin
            note(EV_BAD_REQ, 0, 0, 0, 0, 1);
        end else if (kind == K_MAP) begin
            map_page(pid, req_vpage, val);
        end else begin
            access_page(pid, va, req_vpage, val, kind == K_STORE);
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
        o_events_checked = 0;
        o_pagings = 0;
        clear_model();
    end

    always @(posedge i_clk) begin
        t_event got;
        t_event want;
        if (!i_rst_n) begin
            clear_model();
            events_q.delete();
        end else begin
            if (i_valid) begin
                got = '{i_event_res, i_frame_index, i_swap_slot, i_physical_address,
                        i_virtual_page, i_read_data, i_last};
                if (events_q.size() == 0) begin
                    flag($sformatf("unexpected event %0d", i_event_res));
                end else begin
                    want = events_q.pop_front();
                    o_events_checked++;
                    if (got.ev != want.ev)
                        flag($sformatf("event %0d, want %0d", got.ev, want.ev));
                    if (got.fr != want.fr)
                        flag($sformatf("frame %0d, want %0d", got.fr, want.fr));
                    if (got.sl != want.sl)
                        flag($sformatf("slot %0d, want %0d", got.sl, want.sl));
                    if (got.pa != want.pa)
                        flag($sformatf("phys addr %0d, want %0d", got.pa, want.pa));
                    if (got.vp != want.vp)
                        flag($sformatf("vpage %0d, want %0d", got.vp, want.vp));
                    if (got.rd != want.rd)
                        flag($sformatf("read data %0h, want %0h", got.rd, want.rd));
                    if (got.last != want.last)
                        flag($sformatf("last %0d, want %0d", got.last, want.last));
                end
            end
            if (i_start && !i_busy)
                predict_request(i_kind, i_pid, i_virtual_address, i_value);
        end
        o_outstanding = events_q.size();
    end

endmodule

// ===== dv/demand_paging_swap_manager_top_test.sv =====
// ----------------------------------------------------------------------------
// demand_paging_swap_manager_top_test
// Drives map, store and load requests into the paging manager: a directed
// opening over every request kind and every error but a full swap store,
// then mostly well-formed random traffic over all processes with some
// malformed requests, under several request gap patterns. dpm_checker checks.
// ----------------------------------------------------------------------------
module demand_paging_swap_manager_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dpm_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              start = 0;
    logic [KIND_W-1:0] i_kind = '0;
    logic [PID_W-1:0]  i_pid = '0;
    logic [VA_W-1:0]   i_virtual_address = '0;
    logic [BYTE_W-1:0] i_value = '0;
    logic              busy;
    logic              o_valid;
    logic [EV_W-1:0]   o_event_res;
    logic [OFR_W-1:0]  o_frame_index;
    logic [OSL_W-1:0]  o_swap_slot;
    logic [OPA_W-1:0]  o_physical_address;
    logic [OVP_W-1:0]  o_virtual_page;
    logic [BYTE_W-1:0] o_read_data;
    logic              o_last;

    int fail_count;
    int outstanding;
    int events_checked;
    int pagings;
    int requests;
    int gap_pct;

    always #5 i_clk = ~i_clk;

    demand_paging_swap_manager_top u_top (.*);

    dpm_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_kind, .i_pid,
        .i_virtual_address, .i_value, .i_valid(o_valid), .i_event_res(o_event_res),
        .i_frame_index(o_frame_index), .i_swap_slot(o_swap_slot),
        .i_physical_address(o_physical_address), .i_virtual_page(o_virtual_page),
        .i_read_data(o_read_data), .i_last(o_last), .o_fail_count(fail_count),
        .o_outstanding(outstanding), .o_events_checked(events_checked),
        .o_pagings(pagings)
    );

    task automatic request(input logic [KIND_W-1:0] kind, input int pid, input int va,
                           input int val);
        start <= 1'b1;
        i_kind <= kind;
        i_pid <= PID_W'(pid);
        i_virtual_address <= VA_W'(va);
        i_value <= BYTE_W'(val);
        do @(posedge i_clk); while (busy);
        requests++;
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            request(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 3),
                    $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (r < 40) begin
            request(K_MAP, $urandom_range(0, 3), $urandom_range(0, VA_LIMIT - 1),
                    ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 1));
        end else begin
            request(r < 70 ? K_STORE : K_LOAD, $urandom_range(0, 3),
                    $urandom_range(0, VA_LIMIT - 1), $urandom_range(0, 255));
        end
    endtask

    initial begin
        requests = 0;
        gap_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        request(K_LOAD, 3, 0, 0);
        request(K_MAP, 0, 0, 1);
        request(K_STORE, 0, 5, 8'hff);
        request(K_LOAD, 0, 5, 0);
        request(K_MAP, 0, 3, 1);
        request(K_MAP, 0, 7, 0);
        request(K_STORE, 0, 7, 8'h5a);
        request(K_MAP, 0, 9, 2);
        request(K_MAP, 0, 9, 8'hff);
        request(K_BAD, 0, 0, 0);
        request(K_LOAD, 0, 64, 0);
        request(K_STORE, 1, 255, 8'h00);
        request(K_LOAD, 0, 63, 0);
        request(K_MAP, 1, 16, 1);
        request(K_MAP, 2, 32, 0);
        request(K_MAP, 3, 48, 1);
        request(K_STORE, 1, 31, 8'ha5);
        request(K_STORE, 2, 40, 8'h11);
        request(K_LOAD, 0, 5, 0);
        request(K_LOAD, 3, 50, 0);
        request(K_MAP, 1, 63, 1);
        request(K_LOAD, 1, 31, 0);

        for (int phase = 0; phase < 4; phase++) begin
            gap_pct = (phase == 1) ? 66 : (phase == 2) ? 35 : 0;
            repeat (95) random_request();
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (busy || outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("%0d requests sent, %0d events checked, %0d page movements seen",
                 requests, events_checked, pagings);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d events outstanding", outstanding);
        $display("Verification failed");
        $finish;
    end

endmodule
